### rtl/phc_pkg.sv
package phc_pkg;

  // Sample and hue fixed-point formats.
  localparam int SampleWidth  = 32;
  localparam int DensityWidth = 16;
  localparam int ColorWidth   = 8;
  localparam int HueFracBits  = 8;

  // The hue quotient is at most 6.0, so it needs three integer bits.
  localparam int QuotWidth   = HueFracBits + 3;
  localparam int DivSteps    = QuotWidth;
  localparam int DivCntWidth = $clog2(DivSteps);

  localparam logic [QuotWidth-1:0]  HueFull   = QuotWidth'(6 * (1 << HueFracBits));
  localparam logic [ColorWidth-1:0] ColorMax  = '1;
  localparam logic [ColorWidth-1:0] GrayReset = 8'hBB;

  // Configuration register indexes.
  localparam int CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] CfgShowPressure = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgGrayLevel    = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic update;
    logic diff;
    logic scale;
    logic div_step;
    logic color;
  } phc_cmd_t;

endpackage

### rtl/phc_stream_if.sv
// Input channel: one grid cell per transaction.
interface phc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [phc_pkg::SampleWidth-1:0]  pressure_sample;
  logic        [phc_pkg::DensityWidth-1:0] density_sample;

  modport source (output valid, output pressure_sample, output density_sample, input ready);
  modport sink   (input valid, input pressure_sample, input density_sample, output ready);
endinterface

// Output channel: one RGBA color per transaction.
interface phc_out_if;
  logic                              valid;
  logic                              ready;
  logic [phc_pkg::ColorWidth-1:0]    red;
  logic [phc_pkg::ColorWidth-1:0]    green;
  logic [phc_pkg::ColorWidth-1:0]    blue;
  logic [phc_pkg::ColorWidth-1:0]    alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

### rtl/phc_datapath.sv
module phc_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  phc_pkg::phc_cmd_t                     cmd_i,
  input  logic                                  show_pressure_i,
  input  logic [phc_pkg::ColorWidth-1:0]        gray_level_i,
  input  logic signed [phc_pkg::SampleWidth-1:0] pressure_i,
  input  logic [phc_pkg::DensityWidth-1:0]      density_i,
  output logic [phc_pkg::ColorWidth-1:0]        red_o,
  output logic [phc_pkg::ColorWidth-1:0]        green_o,
  output logic [phc_pkg::ColorWidth-1:0]        blue_o,
  output logic [phc_pkg::ColorWidth-1:0]        alpha_o
);
  import phc_pkg::*;

  localparam logic signed [SampleWidth-1:0] MostPos = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic signed [SampleWidth-1:0] MostNeg = {1'b1, {(SampleWidth-1){1'b0}}};
  localparam logic [HueFracBits+1:0]        TwoOne  = (HueFracBits+2)'(1 << (HueFracBits+1));

  logic signed [SampleWidth-1:0]  p_q;
  logic [DensityWidth-1:0]        dens_q;
  logic signed [SampleWidth-1:0]  min_q, max_q;
  logic [SampleWidth-1:0]         d_q, range_q, rem_q;
  logic [2:0]                     num_low_q;
  logic [QuotWidth-1:0]           quot_q;
  logic                           flat_q;
  logic [ColorWidth-1:0]          red_q, green_q, blue_q, alpha_q;

  logic [SampleWidth+2:0]         six_d;
  logic [SampleWidth:0]           trial;
  logic                           qbit;
  logic [QuotWidth-1:0]           hue, hue_m1;
  logic [HueFracBits:0]           hue_mod, x;
  logic [HueFracBits+ColorWidth:0] x_scaled;
  logic [ColorWidth-1:0]          xc;
  logic [2:0]                     seg;
  logic [ColorWidth-1:0]          r_hue, g_hue, b_hue;

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p_q    <= pressure_i;
      dens_q <= density_i;
    end
  end

  // Running extremes, updated before the cell is colored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MostPos;
      max_q <= MostNeg;
    end else if (cmd_i.update) begin
      if (p_q > max_q) max_q <= p_q;
      if (p_q < min_q) min_q <= p_q;
    end
  end

  // Times six as two shifted copies added together.
  assign six_d = {1'b0, d_q, 2'b00} + {2'b00, d_q, 1'b0};

  // One restoring division step: shift in the next numerator bit, then subtract.
  assign trial = {rem_q, num_low_q[2]};
  assign qbit  = (trial >= {1'b0, range_q});

  // The remainder starts at six times d over eight, which is already below the range.
  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      d_q     <= SampleWidth'(p_q - min_q);
      range_q <= SampleWidth'(max_q - min_q);
    end
    if (cmd_i.scale) begin
      rem_q     <= six_d[SampleWidth+2:3];
      num_low_q <= six_d[2:0];
      quot_q    <= '0;
      flat_q    <= (range_q == '0);
    end else if (cmd_i.div_step) begin
      rem_q     <= qbit ? SampleWidth'(trial - {1'b0, range_q}) : trial[SampleWidth-1:0];
      num_low_q <= {num_low_q[1:0], 1'b0};
      quot_q    <= {quot_q[QuotWidth-2:0], qbit};
    end
  end

  // Hue ramp: triangle ramp within each segment, scaled to 0..255.
  assign hue      = flat_q ? '0 : HueFull - quot_q;
  assign hue_m1   = hue - QuotWidth'(1);
  assign hue_mod  = hue[HueFracBits:0];
  assign x        = hue_mod[HueFracBits] ? (HueFracBits+1)'(TwoOne - {1'b0, hue_mod}) : hue_mod;
  assign x_scaled = {x, {ColorWidth{1'b0}}} - {{ColorWidth{1'b0}}, x};
  assign xc       = x_scaled[HueFracBits+ColorWidth-1:HueFracBits];
  assign seg      = (hue == '0) ? 3'd0 : hue_m1[QuotWidth-1:HueFracBits];

  always_comb begin
    case (seg)
      3'd0: begin r_hue = ColorMax; g_hue = xc;       b_hue = '0;       end
      3'd1: begin r_hue = xc;       g_hue = ColorMax; b_hue = '0;       end
      3'd2: begin r_hue = '0;       g_hue = ColorMax; b_hue = xc;       end
      3'd3: begin r_hue = '0;       g_hue = xc;       b_hue = ColorMax; end
      3'd4: begin r_hue = xc;       g_hue = '0;       b_hue = ColorMax; end
      3'd5: begin r_hue = ColorMax; g_hue = '0;       b_hue = xc;       end
      default: begin r_hue = '0;    g_hue = '0;       b_hue = '0;       end
    endcase
  end

  // Output register, held until the next color command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.color) begin
      if (show_pressure_i) begin
        red_q   <= r_hue;
        green_q <= g_hue;
        blue_q  <= b_hue;
        alpha_q <= ColorMax;
      end else begin
        red_q   <= gray_level_i;
        green_q <= gray_level_i;
        blue_q  <= gray_level_i;
        alpha_q <= (|dens_q[DensityWidth-1:ColorWidth]) ? ColorMax : dens_q[ColorWidth-1:0];
      end
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign alpha_o = alpha_q;

  // The extremes move only on an update command.
  a_max_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(max_q) |-> $past(cmd_i.update)) else $error("max changed outside update");
  a_min_only_on_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(min_q) |-> $past(cmd_i.update)) else $error("min changed outside update");

endmodule

### rtl/phc_ctrl.sv
module phc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output phc_pkg::phc_cmd_t cmd_o
);
  import phc_pkg::*;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StUpdate = 6'b000010,
    StDiff   = 6'b000100,
    StScale  = 6'b001000,
    StDiv    = 6'b010000,
    StColor  = 6'b100000
  } phc_state_e;

  phc_state_e             state_q, state_d;
  logic [DivCntWidth-1:0] cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic                   in_fire;

  assign in_ready_o  = (state_q == StIdle);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Sequencer: update extremes, form operands, divide, then color.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.load = in_fire;
        if (in_fire) state_d = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StDiff;
      end
      StDiff: begin
        cmd_o.diff = 1'b1;
        state_d    = StScale;
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        cnt_d       = '0;
        state_d     = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + DivCntWidth'(1);
        if (cnt_q == DivCntWidth'(DivSteps - 1)) state_d = StColor;
      end
      StColor: begin
        // Wait while the previous result still sits unread in the output register.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.color = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Output valid flag for the result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.color) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_fire_starts_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == StUpdate) else $error("accepted cell did not start an update");
  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && cnt_q == DivCntWidth'(DivSteps - 1)) |=> state_q == StColor)
    else $error("division did not end after the last step");
  a_result_from_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StColor))
    else $error("result appeared outside the color step");

endmodule

### rtl/pressure_heatmap_colorizer.sv
// Channel     | Dir | Payload                                | Transfer
// in_if_i     | in  | pressure_sample s32, density_sample u16 | valid && ready
// out_if_o    | out | red, green, blue, alpha (8 bits each)   | valid && ready
// cfg_*_i     | in  | index 0 show_pressure, 1 gray_level     | cfg_we_i high
//
// Each cell goes from acceptance to the next accept through these steps in order:
// update the extremes, form the operands and scale, eleven steps of the radix-2 divider
// that forms the hue quotient, and finally color and load the output register.
// A new cell is accepted while the previous result waits in the output register; the
// color step stalls only if that result is still unread.
// Reset (rst_ni low, asynchronous) restores the extremes and configuration registers.
module pressure_heatmap_colorizer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  phc_in_if.sink                                in_if_i,
  phc_out_if.source                             out_if_o,
  input  logic                                  cfg_we_i,
  input  logic [phc_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [phc_pkg::ColorWidth-1:0]        cfg_wdata_i
);
  import phc_pkg::*;

  logic                  show_pressure_q;
  logic [ColorWidth-1:0] gray_level_q;
  phc_cmd_t              cmd;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      show_pressure_q <= 1'b0;
      gray_level_q    <= GrayReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgShowPressure: show_pressure_q <= cfg_wdata_i[0];
        CfgGrayLevel:    gray_level_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  phc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if_i.valid),
    .in_ready_o  (in_if_i.ready),
    .out_valid_o (out_if_o.valid),
    .out_ready_i (out_if_o.ready),
    .cmd_o       (cmd)
  );

  phc_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .show_pressure_i (show_pressure_q),
    .gray_level_i    (gray_level_q),
    .pressure_i      (in_if_i.pressure_sample),
    .density_i       (in_if_i.density_sample),
    .red_o           (out_if_o.red),
    .green_o         (out_if_o.green),
    .blue_o          (out_if_o.blue),
    .alpha_o         (out_if_o.alpha)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import phc_pkg::*;

  // One RGBA color as the block delivers it.
  typedef struct packed {
    logic [ColorWidth-1:0] red;
    logic [ColorWidth-1:0] green;
    logic [ColorWidth-1:0] blue;
    logic [ColorWidth-1:0] alpha;
  } rgba_t;

  localparam int unsigned HueOne   = 1 << HueFracBits;
  localparam int unsigned DrainGap = 40;

  logic clk;
  logic rst_n;
  logic                   cfg_we;
  logic [CfgIdxWidth-1:0] cfg_idx;
  logic [ColorWidth-1:0]  cfg_wdata;

  phc_in_if  in_if ();
  phc_out_if out_if ();

  pressure_heatmap_colorizer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_if_i     (in_if),
    .out_if_o    (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Shadow of the block: running extremes and configuration.
  logic signed [SampleWidth-1:0] low_pressure;
  logic signed [SampleWidth-1:0] high_pressure;
  logic                          shade_by_pressure;
  logic [ColorWidth-1:0]         gray_shade;

  rgba_t       pending_colors[$];
  int unsigned error_count;
  int unsigned send_gap_max;
  int unsigned recv_gap_max;
  int unsigned stall_len;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Updates the extremes with one cell and works out the color it must get.
  function automatic rgba_t colorize_cell(logic signed [SampleWidth-1:0] p,
                                          logic [DensityWidth-1:0] dens);
    rgba_t           c;
    longint unsigned span;
    longint unsigned offs;
    longint unsigned quot;
    int unsigned     hue;
    int unsigned     m;
    int unsigned     x;
    int unsigned     xc;
    int unsigned     seg;
    if (p > high_pressure) high_pressure = p;
    if (p < low_pressure) low_pressure = p;
    if (shade_by_pressure) begin
      span = longint'(high_pressure) - longint'(low_pressure);
      if (span == 0) begin
        hue = 0;
      end else begin
        offs = longint'(p) - longint'(low_pressure);
        quot = ((offs * 6) << HueFracBits) / span;
        hue  = 6 * HueOne - int'(quot);
      end
      // Triangle wave over the hue, then the six-segment ramp.
      m   = hue & (2 * HueOne - 1);
      x   = (m >= HueOne) ? 2 * HueOne - m : m;
      xc  = (x * 255) >> HueFracBits;
      seg = (hue == 0) ? 0 : (hue - 1) >> HueFracBits;
      case (seg)
        0: begin c.red = ColorMax; c.green = xc[7:0]; c.blue = '0; end
        1: begin c.red = xc[7:0]; c.green = ColorMax; c.blue = '0; end
        2: begin c.red = '0; c.green = ColorMax; c.blue = xc[7:0]; end
        3: begin c.red = '0; c.green = xc[7:0]; c.blue = ColorMax; end
        4: begin c.red = xc[7:0]; c.green = '0; c.blue = ColorMax; end
        5: begin c.red = ColorMax; c.green = '0; c.blue = xc[7:0]; end
        default: begin c.red = '0; c.green = '0; c.blue = '0; end
      endcase
      c.alpha = ColorMax;
    end else begin
      c.red   = gray_shade;
      c.green = gray_shade;
      c.blue  = gray_shade;
      c.alpha = (dens > 255) ? ColorMax : dens[7:0];
    end
    return c;
  endfunction

  task automatic check_channel(input string name, input logic [ColorWidth-1:0] want,
                               input logic [ColorWidth-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compares every output transaction with the oldest pending color.
  initial begin : color_monitor
    rgba_t want;
    forever begin
      @(posedge clk);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (pending_colors.size() == 0) begin
          $display("%0t: unexpected color transaction, expected none, actual %0d %0d %0d %0d",
                   $time, out_if.red, out_if.green, out_if.blue, out_if.alpha);
          error_count++;
        end else begin
          want = pending_colors.pop_front();
          check_channel("red", want.red, out_if.red);
          check_channel("green", want.green, out_if.green);
          check_channel("blue", want.blue, out_if.blue);
          check_channel("alpha", want.alpha, out_if.alpha);
        end
      end
    end
  end

  // Output receiver: random hold-off per transaction, or a long stall on request.
  initial begin : color_sink
    int unsigned wait_n;
    out_if.ready = 1'b0;
    forever begin
      if (stall_len != 0) begin
        wait_n    = stall_len;
        stall_len = 0;
      end else begin
        wait_n = $urandom_range(0, recv_gap_max);
      end
      @(negedge clk);
      if (wait_n != 0) begin
        out_if.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  // Offers one cell after a random gap and records its color once accepted.
  task automatic send_cell(input logic signed [SampleWidth-1:0] p,
                           input logic [DensityWidth-1:0] dens);
    int unsigned gap;
    gap = $urandom_range(0, send_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid           <= 1'b1;
    in_if.pressure_sample <= p;
    in_if.density_sample  <= dens;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_colors.push_back(colorize_cell(p, dens));
  endtask

  // Stops offering cells and waits until every pending color has arrived.
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DrainGap) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [ColorWidth-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgShowPressure) shade_by_pressure = val[0];
    else if (idx == CfgGrayLevel) gray_shade = val;
  endtask

  // Density mode with the register values left by reset.
  task automatic test_reset_defaults();
    send_cell(-600, '0);
    send_cell(-600, '1);
    wait_drained();
  endtask

  // All pressures so far are equal, so the range is flat and the color is red.
  task automatic test_flat_range();
    write_reg(CfgShowPressure, 8'h01);
    send_cell(-600, DensityWidth'($urandom));
    send_cell(-600, DensityWidth'($urandom));
    wait_drained();
  endtask

  // Small range of 1200: steps of 100 hit every segment edge and middle.
  task automatic test_hue_segments();
    send_cell(600, DensityWidth'($urandom));
    for (int k = 0; k < 12; k++) send_cell(-600 + 100 * k, DensityWidth'($urandom));
    wait_drained();
  endtask

  // Density clamp at both gray extremes.
  task automatic test_density_clamp();
    write_reg(CfgShowPressure, 8'h00);
    write_reg(CfgGrayLevel, 8'h00);
    send_cell(0, 16'd0);
    send_cell(0, 16'd255);
    send_cell(0, 16'd256);
    wait_drained();
    write_reg(CfgGrayLevel, ColorMax);
    send_cell(0, 16'hFFFF);
    send_cell(0, 16'd1);
    wait_drained();
  endtask

  // Random cells in phases with widening pressure bands and varied settings.
  task automatic test_random_phases();
    logic signed [SampleWidth-1:0] raw;
    logic signed [SampleWidth-1:0] p;
    logic [DensityWidth-1:0]       dens;
    logic [ColorWidth-1:0]         show_val;
    int unsigned                   band;
    int unsigned                   pick;
    for (int ph = 0; ph < 6; ph++) begin
      show_val    = ColorWidth'($urandom);
      show_val[0] = (ph % 2 == 0);
      write_reg(CfgShowPressure, show_val);
      case (ph)
        1:       write_reg(CfgGrayLevel, 8'h00);
        3:       write_reg(CfgGrayLevel, ColorMax);
        default: write_reg(CfgGrayLevel, ColorWidth'($urandom));
      endcase
      send_gap_max = (ph >= 4) ? 0 : 8;
      recv_gap_max = (ph == 4) ? 0 : 8;
      band         = 12 + 4 * ph;
      // Long output stall while cells keep coming, so the input backs up.
      if (ph == 2) stall_len = 300;
      for (int n = 0; n < 70; n++) begin
        // Pause mid-phase until every pending color has been delivered.
        if (ph == 3 && n == 35) wait_drained();
        pick = $urandom_range(0, 9);
        raw  = $urandom;
        case (pick)
          0:       p = low_pressure;
          1:       p = high_pressure;
          2:       p = low_pressure + $urandom_range(0, 15);
          3:       p = high_pressure - $urandom_range(0, 15);
          default: p = raw >>> (SampleWidth - band);
        endcase
        if ($urandom_range(0, 3) == 0) dens = DensityWidth'($urandom_range(0, 300));
        else dens = DensityWidth'($urandom);
        send_cell(p, dens);
      end
      wait_drained();
    end
    send_gap_max = 8;
    recv_gap_max = 8;
  endtask

  // Full-scale extremes, then thirteen points across the whole range.
  task automatic test_full_scale_hue();
    longint pl;
    write_reg(CfgShowPressure, 8'h01);
    send_cell({1'b0, {(SampleWidth - 1){1'b1}}}, DensityWidth'($urandom));
    send_cell({1'b1, {(SampleWidth - 1){1'b0}}}, DensityWidth'($urandom));
    for (int k = 0; k <= 12; k++) begin
      pl = -64'sd2147483648 + (64'sd4294967295 * k) / 12;
      send_cell(pl[SampleWidth-1:0], DensityWidth'($urandom));
    end
    wait_drained();
  endtask

  // Main sequence.
  initial begin : main_seq
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_idx               = '0;
    cfg_wdata             = '0;
    in_if.valid           = 1'b0;
    in_if.pressure_sample = '0;
    in_if.density_sample  = '0;
    error_count           = 0;
    send_gap_max          = 8;
    recv_gap_max          = 8;
    stall_len             = 0;
    low_pressure          = {1'b0, {(SampleWidth - 1){1'b1}}};
    high_pressure         = {1'b1, {(SampleWidth - 1){1'b0}}};
    shade_by_pressure     = 1'b0;
    gray_shade            = GrayReset;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(posedge clk);

    test_reset_defaults();
    test_flat_range();
    test_hue_segments();
    test_density_clamp();
    test_random_phases();
    test_full_scale_hue();

    if (error_count == 0) begin
      $display("** pressure_heatmap_colorizer: PASSED **");
    end else begin
      $display("** pressure_heatmap_colorizer: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #4_000_000;
    $display("** pressure_heatmap_colorizer: FAILED **");
    $finish;
  end

endmodule
